// ===== design/cbq_pkg.sv =====
// shared types and constants for the cascaded biquad filter
package cbq_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_WIDTH   = 24;
	localparam int COEF_WIDTH     = 24;
	localparam int COEF_FRAC_BITS = 20;
	localparam int NUM_SECTIONS   = 2;

	// datapath widths
	localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_WIDTH   = PROD_WIDTH + 3;
	localparam int SHIFT_WIDTH = ACC_WIDTH - COEF_FRAC_BITS;
	localparam int SEC_WIDTH   = $clog2(NUM_SECTIONS);

	// configuration register indexes
	localparam int CFG_IDX_WIDTH = 3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FF_COEF_0 = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FF_COEF_1 = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FF_COEF_2 = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_COEF_1 = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_COEF_2 = 3'd4;

	// one multiply per tap, feedforward taps first
	typedef enum logic [2:0] {
		TAP_X0,
		TAP_X1,
		TAP_X2,
		TAP_Y1,
		TAP_Y2
	} tap_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic                 load_in;
		logic                 mul_en;
		tap_t                 tap;
		logic                 acc_clr;
		logic                 acc_en;
		logic                 round_en;
		logic [SEC_WIDTH-1:0] sec;
		logic                 out_load;
	} cmd_t;

endpackage

// ===== design/cbq_in_if.sv =====
// input sample channel
interface cbq_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// ===== design/cbq_out_if.sv =====
// output sample channel
interface cbq_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// ===== design/cbq_cfg_if.sv =====
// coefficient register write channel
interface cbq_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [cbq_pkg::CFG_IDX_WIDTH-1:0] index;
	logic [cbq_pkg::COEF_WIDTH-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/cascaded_biquad_filter.sv =====
// Two biquad sections in cascade sharing five coefficients, one multiplier
// and one accumulator. A sample is accepted in the idle state, then per
// section one multiply is made for each of the five taps, one step sums the
// last product and one rounds, saturates and updates the history. The
// single shared multiplier means the next sample is not accepted before the
// previous one is finished; the result sits in an output register, so the
// next sample may start while it waits, and the block only stalls at the end
// of the second section if that register is still full. Coefficient writes
// are taken in any cycle and should be made while the block is idle.
module cascaded_biquad_filter (
	input  logic   clk,
	input  logic   arst_n,
	cbq_in_if.sink    smp_in,
	cbq_out_if.source smp_out,
	cbq_cfg_if.sink   cfg
);

	cbq_pkg::cmd_t cmd;

	assign cfg.ready = 1'b1;

	cbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (smp_in.valid),
		.in_ready  (smp_in.ready),
		.out_valid (smp_out.valid),
		.out_ready (smp_out.ready),
		.cmd       (cmd)
	);

	cbq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid && cfg.ready),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.sample_in  (smp_in.sample_in),
		.cmd        (cmd),
		.sample_out (smp_out.sample_out)
	);

endmodule

// ===== design/cbq_ctrl.sv =====
// sequencer for the shared multiply-accumulate datapath
module cbq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output cbq_pkg::cmd_t cmd
);

	cbq_pkg::state_t                 state_q, state_d;
	cbq_pkg::tap_t                   tap_q, tap_d;
	logic [cbq_pkg::SEC_WIDTH-1:0]   sec_q, sec_d;
	logic                            out_valid_q;
	logic                            last_sec;

	assign last_sec  = (sec_q == cbq_pkg::SEC_WIDTH'(cbq_pkg::NUM_SECTIONS - 1));
	assign out_valid = out_valid_q;

	// state, tap and section registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbq_pkg::ST_IDLE;
			tap_q   <= cbq_pkg::TAP_X0;
			sec_q   <= '0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
			sec_q   <= sec_d;
		end
	end

	// output valid: set on load, cleared once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		tap_d        = tap_q;
		sec_d        = sec_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.tap      = tap_q;
		cmd.sec      = sec_q;
		case (state_q)
			cbq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					sec_d       = '0;
					tap_d       = cbq_pkg::TAP_X0;
					state_d     = cbq_pkg::ST_MAC;
				end
			end
			cbq_pkg::ST_MAC: begin
				// product of the previous tap is summed while this one multiplies
				cmd.mul_en  = 1'b1;
				cmd.acc_clr = (tap_q == cbq_pkg::TAP_X0);
				cmd.acc_en  = (tap_q != cbq_pkg::TAP_X0);
				if (tap_q == cbq_pkg::TAP_Y2) begin
					state_d = cbq_pkg::ST_DRAIN;
				end else begin
					tap_d = cbq_pkg::tap_t'(tap_q + 3'd1);
				end
			end
			cbq_pkg::ST_DRAIN: begin
				cmd.acc_en = 1'b1;
				state_d    = cbq_pkg::ST_ROUND;
			end
			cbq_pkg::ST_ROUND: begin
				if (!last_sec) begin
					cmd.round_en = 1'b1;
					sec_d        = sec_q + 1'b1;
					tap_d        = cbq_pkg::TAP_X0;
					state_d      = cbq_pkg::ST_MAC;
				end else if (!out_valid_q || out_ready) begin
					// wait here while the previous result is still held
					cmd.round_en = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = cbq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cbq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/cbq_datapath.sv =====
// coefficient registers, section history, multiplier and accumulator
module cbq_datapath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [cbq_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
	input  logic [cbq_pkg::COEF_WIDTH-1:0]          cfg_data,
	input  logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] sample_in,
	input  cbq_pkg::cmd_t                           cmd,
	output logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] sample_out
);

	localparam int SW = cbq_pkg::SAMPLE_WIDTH;
	localparam int AW = cbq_pkg::ACC_WIDTH;
	localparam int HW = cbq_pkg::SHIFT_WIDTH;
	localparam int NS = cbq_pkg::NUM_SECTIONS;

	localparam logic signed [AW-1:0] HALF_LSB = AW'(1) << (cbq_pkg::COEF_FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};

	logic signed [cbq_pkg::COEF_WIDTH-1:0] ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
	logic signed [SW-1:0] xp_q [NS];
	logic signed [SW-1:0] xp2_q [NS];
	logic signed [SW-1:0] yp_q [NS];
	logic signed [SW-1:0] yp2_q [NS];
	logic signed [SW-1:0] x_cur_q;
	logic signed [SW-1:0] sample_out_q;

	logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_mux;
	logic signed [SW-1:0]                  op_mux;
	logic signed [cbq_pkg::PROD_WIDTH-1:0] prod_s1;
	logic                                  sub_s1;
	logic signed [AW-1:0]                  acc_q;
	logic signed [AW-1:0]                  acc_rnd;
	logic signed [HW-1:0]                  shifted;
	logic [HW-SW:0]                        upper_bits;
	logic signed [SW-1:0]                  y_sat;

	assign sample_out = sample_out_q;

	// coefficient registers, writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff0_q <= '0;
			ff1_q <= '0;
			ff2_q <= '0;
			fb1_q <= '0;
			fb2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cbq_pkg::REG_FF_COEF_0: ff0_q <= cfg_data;
				cbq_pkg::REG_FF_COEF_1: ff1_q <= cfg_data;
				cbq_pkg::REG_FF_COEF_2: ff2_q <= cfg_data;
				cbq_pkg::REG_FB_COEF_1: fb1_q <= cfg_data;
				cbq_pkg::REG_FB_COEF_2: fb2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select for the current tap
	always_comb begin
		case (cmd.tap)
			cbq_pkg::TAP_X0: begin coef_mux = ff0_q; op_mux = x_cur_q;        end
			cbq_pkg::TAP_X1: begin coef_mux = ff1_q; op_mux = xp_q[cmd.sec];  end
			cbq_pkg::TAP_X2: begin coef_mux = ff2_q; op_mux = xp2_q[cmd.sec]; end
			cbq_pkg::TAP_Y1: begin coef_mux = fb1_q; op_mux = yp_q[cmd.sec];  end
			cbq_pkg::TAP_Y2: begin coef_mux = fb2_q; op_mux = yp2_q[cmd.sec]; end
			default:         begin coef_mux = '0;    op_mux = '0;             end
		endcase
	end

	// multiplier stage, feedback taps are subtracted
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= coef_mux * op_mux;
			sub_s1  <= (cmd.tap == cbq_pkg::TAP_Y1) || (cmd.tap == cbq_pkg::TAP_Y2);
		end
	end

	// exact accumulation of the five products
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			if (sub_s1) begin
				acc_q <= acc_q - AW'(prod_s1);
			end else begin
				acc_q <= acc_q + AW'(prod_s1);
			end
		end
	end

	// round half up, drop fraction bits, saturate to sample range
	always_comb begin
		acc_rnd    = acc_q + HALF_LSB;
		shifted    = HW'(acc_rnd >>> cbq_pkg::COEF_FRAC_BITS);
		upper_bits = shifted[HW-1:SW-1];
		if ((&upper_bits) || !(|upper_bits)) begin
			y_sat = shifted[SW-1:0];
		end else if (shifted[HW-1]) begin
			y_sat = SAMPLE_MIN;
		end else begin
			y_sat = SAMPLE_MAX;
		end
	end

	// section history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				xp_q[i]  <= '0;
				xp2_q[i] <= '0;
				yp_q[i]  <= '0;
				yp2_q[i] <= '0;
			end
		end else if (cmd.round_en) begin
			xp2_q[cmd.sec] <= xp_q[cmd.sec];
			xp_q[cmd.sec]  <= x_cur_q;
			yp2_q[cmd.sec] <= yp_q[cmd.sec];
			yp_q[cmd.sec]  <= y_sat;
		end
	end

	// section input: new sample, then previous section output
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_cur_q <= sample_in;
		end else if (cmd.round_en) begin
			x_cur_q <= y_sat;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_out_q <= y_sat;
		end
	end

endmodule

// ===== design/cbq_checker.sv =====
// port-level checks for the cascaded biquad filter
module cbq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [cbq_pkg::SAMPLE_WIDTH-1:0] sample_out,
	input logic                              cfg_ready
);

	// the configuration port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// an accepted sample holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transaction");

	// a new result only appears while the input side is busy
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out))
		else $error("result changed while stalled");

endmodule

bind cascaded_biquad_filter cbq_checker u_cbq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (smp_in.valid),
	.in_ready   (smp_in.ready),
	.out_valid  (smp_out.valid),
	.out_ready  (smp_out.ready),
	.sample_out (smp_out.sample_out),
	.cfg_ready  (cfg.ready)
);

// ===== verif/tb_cascaded_biquad_filter.sv =====
// self-checking testbench for the two-section cascaded biquad filter
module tb_cascaded_biquad_filter;
	import cbq_pkg::*;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;

	// input and output history of one section
	typedef struct {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} section_hist_t;

	localparam longint SMP_MAX      = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam longint SMP_MIN      = -SMP_MAX - 1;
	localparam longint COEF_MAX     = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
	localparam longint COEF_MIN     = -COEF_MAX - 1;
	localparam longint UNITY        = longint'(1) <<< COEF_FRAC_BITS;
	localparam longint ROUND_HALF   = longint'(1) <<< (COEF_FRAC_BITS - 1);
	localparam int     RANDOM_ITEMS = 1350;
	localparam int     DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;

	cbq_in_if  in_ch ();
	cbq_out_if out_ch ();
	cbq_cfg_if cfg_ch ();

	cascaded_biquad_filter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp_in  (in_ch),
		.smp_out (out_ch),
		.cfg     (cfg_ch)
	);

	// predictor copy of the coefficients and the section histories
	coef_t         coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
	section_hist_t sec_hist [NUM_SECTIONS];

	sample_t expected_out [$];
	int      error_count = 0;
	int      burst_left  = 0;

	// receiver stall pattern state
	logic [15:0] stall_pat  = 16'hFFFF;
	int          pat_left   = 0;
	int          pat_pos    = 0;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// one direct-form-I section: exact sum, round half up, saturate
	function automatic sample_t run_section(input sample_t x, inout section_hist_t h);
		longint acc;
		longint y;
		acc = longint'(coef_b0) * longint'(x)
		    + longint'(coef_b1) * longint'(h.x1)
		    + longint'(coef_b2) * longint'(h.x2)
		    - longint'(coef_a1) * longint'(h.y1)
		    - longint'(coef_a2) * longint'(h.y2);
		y = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
		if (y > SMP_MAX)
			y = SMP_MAX;
		else if (y < SMP_MIN)
			y = SMP_MIN;
		h.x2 = h.x1;
		h.x1 = x;
		h.y2 = h.y1;
		h.y1 = sample_t'(y);
		return sample_t'(y);
	endfunction

	// filtered sample after every section in turn
	function automatic sample_t filter_sample(input sample_t x);
		sample_t v;
		v = x;
		for (int s = 0; s < NUM_SECTIONS; s++)
			v = run_section(v, sec_hist[s]);
		return v;
	endfunction

	// uniform value in [-span, span]
	function automatic longint rand_span(input longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	function automatic coef_t extreme_coef();
		case ($urandom_range(0, 4))
			0: return coef_t'(COEF_MAX);
			1: return coef_t'(COEF_MIN);
			2: return coef_t'(0);
			3: return coef_t'(UNITY);
			default: return coef_t'(-UNITY);
		endcase
	endfunction

	// send one sample in bursts with random gaps, predict on the transaction
	task automatic push_sample(input sample_t s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		do @(posedge clk); while (!in_ch.ready);
		expected_out.push_back(filter_sample(s));
		burst_left--;
	endtask

	// hold off until every expected result has arrived
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_WIDTH-1:0] idx, input coef_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_FF_COEF_0: coef_b0 = value;
			REG_FF_COEF_1: coef_b1 = value;
			REG_FF_COEF_2: coef_b2 = value;
			REG_FB_COEF_1: coef_a1 = value;
			REG_FB_COEF_2: coef_a2 = value;
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
			input coef_t a1, input coef_t a2);
		wait_idle();
		write_coef(REG_FF_COEF_0, b0);
		write_coef(REG_FF_COEF_1, b1);
		write_coef(REG_FF_COEF_2, b2);
		write_coef(REG_FB_COEF_1, a1);
		write_coef(REG_FB_COEF_2, a2);
	endtask

	// coefficients are zero out of reset, so full-scale input gives zero
	task automatic test_zero_coefs();
		push_sample(sample_t'(SMP_MAX));
		push_sample(sample_t'(SMP_MIN));
	endtask

	// unity b0 passes samples straight through both sections
	task automatic test_passthrough();
		load_coefs(coef_t'(UNITY), '0, '0, '0, '0);
		push_sample(sample_t'(SMP_MAX));
		push_sample(sample_t'(SMP_MIN));
		push_sample(sample_t'(0));
		push_sample(sample_t'(1));
		push_sample(sample_t'(-1));
	endtask

	// writes past the last register must leave the coefficients alone
	task automatic test_unused_index();
		wait_idle();
		for (int k = 1; k <= 3; k++)
			write_coef(CFG_IDX_WIDTH'(REG_FB_COEF_2 + k), coef_t'($urandom()));
		push_sample(sample_t'(12345));
		push_sample(sample_t'(-777));
		push_sample(sample_t'($urandom()));
	endtask

	// half gain puts odd samples exactly on a rounding tie
	task automatic test_rounding();
		load_coefs(coef_t'(UNITY / 2), '0, '0, '0, '0);
		push_sample(sample_t'(1));
		push_sample(sample_t'(-1));
		push_sample(sample_t'(3));
		push_sample(sample_t'(-3));
	endtask

	// largest gains drive both sections into both rails
	task automatic test_saturation();
		load_coefs(coef_t'(COEF_MAX), '0, '0, '0, '0);
		push_sample(sample_t'(SMP_MAX));
		push_sample(sample_t'(SMP_MIN));
		load_coefs(coef_t'(COEF_MIN), '0, '0, '0, '0);
		push_sample(sample_t'(SMP_MAX));
		push_sample(sample_t'(SMP_MIN));
	endtask

	// extreme feedforward and feedback taps, unnormalized
	task automatic test_feedback();
		load_coefs(coef_t'(UNITY), coef_t'(COEF_MIN), coef_t'(COEF_MAX),
			coef_t'(COEF_MIN), coef_t'(COEF_MAX));
		push_sample(sample_t'(SMP_MAX));
		push_sample(sample_t'(0));
		push_sample(sample_t'(SMP_MIN));
		push_sample(sample_t'(4096));
		push_sample(sample_t'(0));
	endtask

	// phases of random coefficient sets, each followed by a random sample stream
	task automatic test_random_filters();
		int    sent;
		int    count;
		int    coef_style;
		int    smp_style;
		coef_t c [5];
		sample_t s;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			coef_style = $urandom_range(0, 3);
			case (coef_style)
				// stable region: |a1| < 1 + a2, a2 < 1
				0, 1: begin
					c[0] = coef_t'(rand_span(UNITY / 4));
					c[1] = coef_t'(rand_span(UNITY / 4));
					c[2] = coef_t'(rand_span(UNITY / 4));
					c[3] = coef_t'(rand_span(UNITY));
					c[4] = coef_t'($urandom_range(0, 32'(UNITY / 2)));
				end
				2: begin
					for (int k = 0; k < 5; k++)
						c[k] = coef_t'($urandom());
				end
				default: begin
					for (int k = 0; k < 5; k++)
						c[k] = extreme_coef();
				end
			endcase
			load_coefs(c[0], c[1], c[2], c[3], c[4]);
			smp_style = $urandom_range(0, 2);
			count = $urandom_range(30, 110);
			if (count > RANDOM_ITEMS - sent)
				count = RANDOM_ITEMS - sent;
			for (int i = 0; i < count; i++) begin
				case (smp_style)
					0: s = sample_t'($urandom());
					1: s = sample_t'(rand_span(longint'(1) <<< 16));
					default: begin
						case ($urandom_range(0, 3))
							0: s = sample_t'(SMP_MAX);
							1: s = sample_t'(SMP_MIN);
							2: s = sample_t'(0);
							default: s = sample_t'($urandom());
						endcase
					end
				endcase
				push_sample(s);
			end
			sent += count;
		end
	endtask

	// receiver ready follows a rotating pattern that changes now and then
	always @(posedge clk) begin
		if (pat_left == 0) begin
			case ($urandom_range(0, 4))
				0, 1: stall_pat = 16'hFFFF;
				2: stall_pat = 16'($urandom()) | 16'h0001;
				3: stall_pat = 16'h0001;
				default: stall_pat = 16'h00FF;
			endcase
			pat_left = $urandom_range(20, 120);
		end
		out_ch.ready <= stall_pat[pat_pos];
		pat_pos  = (pat_pos + 1) % 16;
		pat_left = pat_left - 1;
	end

	// compare each output transaction with the oldest expected sample
	always @(posedge clk) begin
		sample_t exp_smp;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_out.size() == 0) begin
				$error("sample_out unexpected: actual %0d", out_ch.sample_out);
				error_count++;
			end else begin
				exp_smp = expected_out.pop_front();
				if (out_ch.sample_out !== exp_smp) begin
					$error("sample_out mismatch: expected %0d, actual %0d",
						exp_smp, out_ch.sample_out);
					error_count++;
				end
			end
		end
	end

	// stimulus sequence
	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_FF_COEF_0;
		cfg_ch.data     = '0;
		coef_b0 = '0;
		coef_b1 = '0;
		coef_b2 = '0;
		coef_a1 = '0;
		coef_a2 = '0;
		for (int s = 0; s < NUM_SECTIONS; s++)
			sec_hist[s] = '{default: '0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_coefs();
		test_passthrough();
		test_unused_index();
		test_rounding();
		test_saturation();
		test_feedback();
		test_random_filters();
		wait_idle();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 800000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
